>>> rtl/core/npe_pkg.sv
package npe_pkg;

  localparam int WORD_W = 32;

  // one input transaction
  typedef struct packed {
    logic signed [WORD_W-1:0] element;
    logic                     is_last;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic signed [WORD_W-1:0] element_out;
    logic                     last_out;
    logic                     wrapped;
    logic                     truncated;
  } out_item_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SWAP,
    S_REV_TEST,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

>>> rtl/core/next_permutation_engine.sv
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      in_item_t  (element, is_last)
// result    out        result_valid / result_ready  out_item_t (element_out, last_out,
//                                                              wrapped, truncated)
//
// loading accepts one element per cycle; item_ready drops once is_last is taken.
// after the last element all work goes through the single read port of the store:
// a scan for the rightmost ascent, a search for the swap partner, the swap, the
// reversal of the suffix (of the whole sequence on wrap), then emission of each result.
// reset (rst, synchronous) empties the sequence; the store itself is not cleared.
// a stalled result port holds emission; new items are taken again after the
// final result enters the output register.
module next_permutation_engine import npe_pkg::*; #(
  parameter int MAX_LEN = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = AW + 1;

  state_t state, state_next;

  logic [CW-1:0]            cnt;
  logic                     ovf;
  logic [AW-1:0]            ptr;
  logic [AW-1:0]            d;
  logic [AW-1:0]            j;
  logic [AW-1:0]            lo;
  logic [AW-1:0]            hi;
  logic                     first;
  logic                     wrap;
  logic signed [WORD_W-1:0] right;
  logic signed [WORD_W-1:0] pivot;
  logic [WORD_W-1:0]        tmp;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [WORD_W-1:0]        wdata;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;

  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            last_idx;
  logic                     has_room;
  logic                     out_free;
  logic                     accept;
  logic                     ascent;
  logic                     keep_search;
  logic                     at_last;

  assign cnt_m1      = cnt - CW'(1);
  assign last_idx    = cnt_m1[AW-1:0];
  assign has_room    = cnt < CW'(MAX_LEN);
  assign out_free    = !result_valid || result_ready;
  assign item_ready  = (state == S_LOAD);
  assign accept      = item_valid && item_ready;
  assign ascent      = !first && ($signed(rdata) < right);
  assign keep_search = ({1'b0, j} > ({1'b0, d} + PW'(1))) && !(pivot < $signed(rdata));
  assign at_last     = (ptr == last_idx);

  npe_store #(
    .DEPTH(MAX_LEN),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and store port control
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = cnt[AW-1:0];
    wdata      = item.element;
    raddr      = ptr;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          we = has_room;
          if (item.is_last) begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (ascent) begin
          state_next = S_SRCH_RD;
        end else if (ptr == '0) begin
          state_next = S_REV_TEST;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SRCH_RD: begin
        raddr      = j;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        raddr = j;
        if (keep_search) begin
          state_next = S_SRCH_RD;
        end else begin
          we         = 1'b1;
          waddr      = d;
          wdata      = rdata;
          state_next = S_SWAP;
        end
      end
      S_SWAP: begin
        we         = 1'b1;
        waddr      = j;
        wdata      = pivot;
        state_next = S_REV_TEST;
      end
      S_REV_TEST: begin
        state_next = (lo < hi) ? S_REV_RD_LO : S_EMIT_RD;
      end
      S_REV_RD_LO: begin
        raddr      = lo;
        state_next = S_REV_RD_HI;
      end
      S_REV_RD_HI: begin
        raddr      = hi;
        state_next = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        we         = 1'b1;
        waddr      = lo;
        wdata      = rdata;
        state_next = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        we         = 1'b1;
        waddr      = hi;
        wdata      = tmp;
        state_next = S_REV_TEST;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          state_next = at_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // sequence length and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (has_room) begin
        cnt <= cnt + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end else if (state == S_EMIT_OUT && out_free && at_last) begin
      cnt <= '0;
      ovf <= 1'b0;
    end
  end

  // pointers and working values
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (accept && item.is_last) begin
          ptr   <= has_room ? cnt[AW-1:0] : AW'(MAX_LEN - 1);
          first <= 1'b1;
        end
      end
      S_SCAN_CHK: begin
        first <= 1'b0;
        right <= $signed(rdata);
        if (ascent) begin
          d     <= ptr;
          pivot <= $signed(rdata);
          j     <= last_idx;
          lo    <= ptr + AW'(1);
          hi    <= last_idx;
          wrap  <= 1'b0;
        end else if (ptr == '0) begin
          wrap <= 1'b1;
          lo   <= '0;
          hi   <= last_idx;
        end else begin
          ptr <= ptr - AW'(1);
        end
      end
      S_SRCH_CHK: begin
        if (keep_search) begin
          j <= j - AW'(1);
        end
      end
      S_REV_TEST: begin
        if (!(lo < hi)) begin
          ptr <= '0;
        end
      end
      S_REV_RD_HI: begin
        tmp <= rdata;
      end
      S_REV_WR_HI: begin
        lo <= lo + AW'(1);
        hi <= hi - AW'(1);
      end
      S_EMIT_OUT: begin
        if (out_free && !at_last) begin
          ptr <= ptr + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_EMIT_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_OUT && out_free) begin
      result.element_out <= $signed(rdata);
      result.last_out    <= at_last;
      result.wrapped     <= wrap;
      result.truncated   <= ovf;
    end
  end

endmodule

>>> rtl/core/npe_store.sv
module npe_store import npe_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/npe_checker.sv
module npe_checker import npe_pkg::*; #(
  parameter int MAX_LEN = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  in_item_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_item_t result,
  output int        failures,
  output int        pending
);

  // words of the sequence being loaded
  logic signed [WORD_W-1:0] seq_words [MAX_LEN];
  int                       seq_len;
  logic                     seq_dropped;

  // permutation words still owed by the block, oldest first
  out_item_t due_words [$];
  int        fail_tally = 0;

  assign failures = fail_tally;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_tally++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // next lexicographic permutation of the loaded words, queued as results
  task automatic predict_next_permutation();
    logic signed [WORD_W-1:0] w [MAX_LEN];
    logic signed [WORD_W-1:0] t;
    out_item_t                r;
    int                       n;
    int                       pivot;
    int                       j;
    int                       lo;
    int                       hi;
    logic                     wrap;
    n = seq_len;
    w = seq_words;
    pivot = -1;
    // rightmost ascent, signed compare
    for (int i = n - 1; i >= 1 && pivot < 0; i--) begin
      if (w[i-1] < w[i]) pivot = i - 1;
    end
    wrap = (pivot < 0);
    if (!wrap) begin
      // rightmost later word strictly above the pivot
      j = n - 1;
      while (j > pivot + 1 && !(w[pivot] < w[j])) j--;
      t = w[pivot];
      w[pivot] = w[j];
      w[j] = t;
      lo = pivot + 1;
    end else begin
      lo = 0;
    end
    // reverse the suffix, or everything on wrap
    hi = n - 1;
    while (lo < hi) begin
      t = w[lo];
      w[lo] = w[hi];
      w[hi] = t;
      lo++;
      hi--;
    end
    for (int i = 0; i < n; i++) begin
      r.element_out = w[i];
      r.last_out    = (i == n - 1);
      r.wrapped     = wrap;
      r.truncated   = seq_dropped;
      due_words.push_back(r);
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      seq_len = 0;
      seq_dropped = 1'b0;
      due_words.delete();
    end else begin
      // input transaction: store or drop, run the permutation on the last one
      if (item_valid && item_ready) begin
        if (seq_len < MAX_LEN) begin
          seq_words[seq_len] = item.element;
          seq_len++;
        end else begin
          seq_dropped = 1'b1;
        end
        if (item.is_last) begin
          predict_next_permutation();
          seq_len = 0;
          seq_dropped = 1'b0;
        end
      end
      // result transaction against the oldest word due
      if (result_valid && result_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch("result with nothing due, element", result.element_out, 0);
        end else begin
          want = due_words.pop_front();
          if (result.element_out !== want.element_out)
            report_mismatch("element_out", result.element_out, want.element_out);
          if (result.last_out !== want.last_out)
            report_mismatch("last_out", result.last_out, want.last_out);
          if (result.wrapped !== want.wrapped)
            report_mismatch("wrapped", result.wrapped, want.wrapped);
          if (result.truncated !== want.truncated)
            report_mismatch("truncated", result.truncated, want.truncated);
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

>>> tb/next_permutation_engine_tb.sv
module next_permutation_engine_tb import npe_pkg::*;;

  localparam int DEPTH        = 16;
  localparam int ITEM_TARGET  = 380;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_AFTER   = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int WORD_MAX     = 2147483647;
  localparam int WORD_MIN     = -2147483647 - 1;

  // how a random sequence is filled
  typedef enum int {
    FILL_FULL,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_FALLING
  } fill_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  int failures;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  always #5 clk = ~clk;

  next_permutation_engine #(.MAX_LEN(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  npe_checker #(.MAX_LEN(DEPTH)) perm_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .failures     (failures),
    .pending      (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one input transaction after a random gap
  task automatic offer_element(input int value, input bit last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{element: value, is_last: last};
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic offer_sequence(input int vals[$]);
    for (int i = 0; i < vals.size(); i++) offer_element(vals[i], i == vals.size() - 1);
  endtask

  // stop offering and wait for every permutation word due
  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, bursts, and one long hold-off
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_seen % 16 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 4);
      if (!held && results_seen >= HOLD_AFTER) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      results_seen++;
    end
  end

  // stimulus and verdict
  initial begin
    int    vals[$];
    int    len;
    int    pick;
    fill_t fill;
    bit    paused;
    paused = 1'b0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single word, extremes, signed order, duplicates, short suffix
    offer_sequence('{WORD_MAX});
    offer_sequence('{WORD_MIN, WORD_MAX});
    offer_sequence('{WORD_MAX, WORD_MIN});
    offer_sequence('{-1, 0});
    offer_sequence('{1, 3, 3, 2});
    offer_sequence('{5, 5, 5});
    offer_sequence('{3, 1, 2});
    offer_sequence('{0, -1, WORD_MIN, WORD_MAX});
    wait_for_results();

    // random sequences, mostly short, some full or overflowing the store
    while (items_sent < ITEM_TARGET) begin
      send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 8);
      else if (pick < 9) len = $urandom_range(9, DEPTH);
      else len = $urandom_range(DEPTH + 1, DEPTH + 4);
      fill = fill_t'($urandom_range(0, 3));
      vals.delete();
      repeat (len) begin
        case (fill)
          FILL_NARROW: vals.push_back($urandom_range(0, 6) - 3);
          FILL_EXTREME: begin
            case ($urandom_range(0, 3))
              0: vals.push_back(WORD_MIN);
              1: vals.push_back(WORD_MAX);
              2: vals.push_back(0);
              default: vals.push_back(-1);
            endcase
          end
          default: vals.push_back($urandom);
        endcase
      end
      // no ascent, so the block wraps
      if (fill == FILL_FALLING) vals.rsort();
      offer_sequence(vals);
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
